FILE: hdl/kpi_pkg.sv
package kpi_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int COORDS    = 3;
  localparam int VAL_W     = COORDS * DATA_W;
  localparam int COUNT_W   = 7;
  localparam int KEY_IDX_W = 6;
  localparam int FACTOR_W  = FRAC_BITS + 1;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = FACTOR_W + 1 + DIFF_W;
  localparam int DCNT_W    = $clog2(FRAC_BITS);
  localparam int COORD_W   = $clog2(COORDS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_LOAD_C,
    ST_PREP,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_SEG,
    RD_SEG_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    key_write;
    logic    load_query;
    logic    scan_adv;
    logic    seg_hit;
    logic    seg_miss;
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    prep;
    logic    classify;
    logic    div_step;
    logic    mul;
    logic    add;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic key_hit;
    logic scan_last;
    logic needs_div;
    logic div_done;
    logic coord_last;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/kpi_if.sv
interface kpi_req_if;
  import kpi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [KEY_IDX_W-1:0] key_index;
  logic [DATA_W-1:0]    key_time;
  logic signed [DATA_W-1:0] key_x;
  logic signed [DATA_W-1:0] key_y;
  logic signed [DATA_W-1:0] key_z;
  logic [DATA_W-1:0]    query_time;

  modport source(output valid, op, key_index, key_time, key_x, key_y, key_z, query_time,
                 input ready);
  modport sink(input valid, op, key_index, key_time, key_x, key_y, key_z, query_time,
               output ready);
endinterface

interface kpi_rsp_if;
  import kpi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] pos_z;
  logic [KEY_IDX_W-1:0]     segment;
  logic                     range_error;

  modport source(output valid, pos_x, pos_y, pos_z, segment, range_error, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, segment, range_error, output ready);
endinterface

interface kpi_cfg_if;
  import kpi_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] key_count;

  modport source(output valid, key_count, input ready);
  modport sink(input valid, key_count, output ready);
endinterface

FILE: hdl/kpi_ram.sv
module kpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/kpi_ctrl.sv
module kpi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_op,
  input  kpi_pkg::status_t status,
  output logic             req_ready,
  output kpi_pkg::cmd_t    cmd
);
  import kpi_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_SEG;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_op == OP_WRITE) begin
            cmd.key_write = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            state_next     = status.single ? ST_LOAD_A : ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_sel = RD_SCAN;
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (status.key_hit) begin
          cmd.seg_hit = 1'b1;
          state_next  = ST_LOAD_A;
        end else if (status.scan_last) begin
          cmd.seg_miss = 1'b1;
          state_next   = ST_LOAD_A;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = ST_SCAN_RD;
        end
      end
      ST_LOAD_A: begin
        cmd.rd_sel = RD_SEG;
        state_next = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        cmd.rd_sel = RD_SEG_NEXT;
        cmd.cap_a  = 1'b1;
        state_next = ST_LOAD_C;
      end
      ST_LOAD_C: begin
        cmd.cap_b  = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_next   = status.needs_div ? ST_DIVIDE : ST_MUL;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = status.coord_last ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/kpi_datapath.sv
module kpi_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  kpi_pkg::cmd_t                    cmd,
  output kpi_pkg::status_t                 status,
  input  logic [kpi_pkg::KEY_IDX_W-1:0]    req_key_index,
  input  logic [kpi_pkg::DATA_W-1:0]       req_key_time,
  input  logic signed [kpi_pkg::DATA_W-1:0] req_key_x,
  input  logic signed [kpi_pkg::DATA_W-1:0] req_key_y,
  input  logic signed [kpi_pkg::DATA_W-1:0] req_key_z,
  input  logic [kpi_pkg::DATA_W-1:0]       req_query_time,
  input  logic                             cfg_valid,
  input  logic [kpi_pkg::COUNT_W-1:0]      cfg_key_count,
  input  logic                             rsp_ready,
  output logic                             rsp_valid,
  output logic signed [kpi_pkg::DATA_W-1:0] pos_x,
  output logic signed [kpi_pkg::DATA_W-1:0] pos_y,
  output logic signed [kpi_pkg::DATA_W-1:0] pos_z,
  output logic [kpi_pkg::KEY_IDX_W-1:0]    segment,
  output logic                             range_error
);
  import kpi_pkg::*;

  logic [COUNT_W-1:0]       key_count;
  logic [COUNT_W-1:0]       n_sat;
  logic [DATA_W-1:0]        qt;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         seg;
  logic                     err;
  logic                     single;
  logic [DATA_W-1:0]        t0;
  logic [DATA_W-1:0]        t1;
  logic [DATA_W-1:0]        v0 [COORDS];
  logic [DATA_W-1:0]        v1 [COORDS];
  logic signed [DIFF_W-1:0] diff [COORDS];
  logic signed [DIFF_W-1:0] num;
  logic signed [DIFF_W-1:0] den;
  logic [FACTOR_W-1:0]      factor;
  logic [DATA_W-1:0]        rem;
  logic [FRAC_BITS-1:0]     quot;
  logic [DCNT_W-1:0]        dcnt;
  logic [COORD_W-1:0]       k;
  logic signed [PROD_W-1:0] prod;
  logic [DATA_W-1:0]        res [COORDS];

  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rd_time;
  logic [VAL_W-1:0]  rd_val;
  logic [DATA_W:0]   rem2;
  logic              sub_ok;
  logic [FRAC_BITS-1:0] quot_next;

  kpi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (cmd.key_write),
    .waddr (IDX_W'(req_key_index)),
    .wdata (req_key_time),
    .raddr (raddr),
    .rdata (rd_time)
  );

  kpi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_value_ram (
    .clk   (clk),
    .we    (cmd.key_write),
    .waddr (IDX_W'(req_key_index)),
    .wdata ({req_key_z, req_key_y, req_key_x}),
    .raddr (raddr),
    .rdata (rd_val)
  );

  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN:     raddr = idx + IDX_W'(1);
      RD_SEG:      raddr = seg;
      RD_SEG_NEXT: raddr = seg + IDX_W'(1);
      default:     raddr = seg;
    endcase
  end

  always_comb begin
    if (key_count == '0) begin
      n_sat = COUNT_W'(1);
    end else if (key_count > COUNT_W'(MAX_KEYS)) begin
      n_sat = COUNT_W'(MAX_KEYS);
    end else begin
      n_sat = key_count;
    end
  end

  assign rem2      = {rem, 1'b0};
  assign sub_ok    = rem2 >= {1'b0, den[DATA_W-1:0]};
  assign quot_next = {quot[FRAC_BITS-2:0], sub_ok};

  assign status.single     = (n_sat == COUNT_W'(1));
  assign status.key_hit    = qt < rd_time;
  assign status.scan_last  = (COUNT_W'(idx) + COUNT_W'(2)) >= n_sat;
  assign status.needs_div  = !single && (den > 0) && (num > 0) && (num < den);
  assign status.div_done   = (dcnt == DCNT_W'(FRAC_BITS - 1));
  assign status.coord_last = (k == COORD_W'(COORDS - 1));
  assign status.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= COUNT_W'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        key_count <= cfg_key_count;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qt     <= req_query_time;
      idx    <= '0;
      seg    <= '0;
      err    <= 1'b0;
      single <= status.single;
    end
    if (cmd.scan_adv) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.seg_hit) begin
      seg <= idx;
    end
    if (cmd.seg_miss) begin
      seg <= '0;
      err <= 1'b1;
    end
    if (cmd.cap_a) begin
      t0 <= rd_time;
      for (int c = 0; c < COORDS; c++) begin
        v0[c] <= rd_val[c*DATA_W +: DATA_W];
      end
    end
    if (cmd.cap_b) begin
      t1 <= rd_time;
      for (int c = 0; c < COORDS; c++) begin
        v1[c] <= rd_val[c*DATA_W +: DATA_W];
      end
    end
    if (cmd.prep) begin
      num <= $signed({1'b0, qt}) - $signed({1'b0, t0});
      den <= $signed({1'b0, t1}) - $signed({1'b0, t0});
      for (int c = 0; c < COORDS; c++) begin
        // Single key: the slot after key 0 may hold nothing, so drop the slope
        if (single) begin
          diff[c] <= '0;
        end else begin
          diff[c] <= $signed({v1[c][DATA_W-1], v1[c]}) - $signed({v0[c][DATA_W-1], v0[c]});
        end
      end
    end
    if (cmd.classify) begin
      dcnt <= '0;
      k    <= '0;
      rem  <= num[DATA_W-1:0];
      quot <= '0;
      // Single key: factor zero, so the start key comes through untouched
      if (single) begin
        factor <= '0;
      end else if (den <= 0) begin
        factor <= FACTOR_ONE;
        err    <= 1'b1;
      end else if (num <= 0) begin
        factor <= '0;
      end else if (num >= den) begin
        factor <= FACTOR_ONE;
      end
    end
    if (cmd.div_step) begin
      rem    <= sub_ok ? DATA_W'(rem2 - {1'b0, den[DATA_W-1:0]}) : rem2[DATA_W-1:0];
      quot   <= quot_next;
      factor <= {1'b0, quot_next};
      dcnt   <= dcnt + DCNT_W'(1);
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, factor}) * diff[k];
    end
    if (cmd.add) begin
      // Arithmetic shift of the product floors; only the low word is kept
      res[k] <= v0[k] + prod[FRAC_BITS +: DATA_W];
      k      <= k + COORD_W'(1);
    end
    if (cmd.out_load) begin
      pos_x       <= res[0];
      pos_y       <= res[1];
      pos_z       <= res[2];
      segment     <= KEY_IDX_W'(seg);
      range_error <= err;
    end
  end

endmodule

FILE: hdl/keyframe_position_interpolator.sv
// Keyframe position interpolator.
// req (sink): one word per item. op = write stores key_time and key_x/y/z in
//   slot key_index and completes in the accept cycle, with no response word.
//   op = query looks up query_time in the key table and answers with one word.
// rsp (source): pos_x/y/z, the segment start index and range_error.
// cfg (sink): key_count, always ready; write it only while no query is open.
// A query searches the keys linearly (none with one key, up to the key count,
//   held to 64, less one), reading each key time from a table with a
//   registered read port. The factor comes from a radix-2 divider, one bit
//   a cycle, only when a true division is needed. One query is in flight at
//   a time.
// Reset clears the controller, drops rsp.valid and sets key_count to 1. The
//   key table holds no reset value: query only keys that have been written.
// A response stalled by rsp.ready holds in the output register; the block
//   still takes writes and the next query, and waits in its final state only
//   when that next answer is ready before the old one has been taken.
module keyframe_position_interpolator (
  input logic      clk,
  input logic      rst,
  kpi_req_if.sink   req,
  kpi_rsp_if.source rsp,
  kpi_cfg_if.sink   cfg
);
  import kpi_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration register is a plain flop: take every word at once
  assign cfg.ready = 1'b1;

  // Sequencer: search, load, divide and interpolate steps
  kpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .status    (status),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // Key tables, divider, multiplier and output register
  kpi_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_key_index  (req.key_index),
    .req_key_time   (req.key_time),
    .req_key_x      (req.key_x),
    .req_key_y      (req.key_y),
    .req_key_z      (req.key_z),
    .req_query_time (req.query_time),
    .cfg_valid      (cfg.valid),
    .cfg_key_count  (cfg.key_count),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .pos_x          (rsp.pos_x),
    .pos_y          (rsp.pos_y),
    .pos_z          (rsp.pos_z),
    .segment        (rsp.segment),
    .range_error    (rsp.range_error)
  );

endmodule

FILE: hdl/kpi_checker.sv
module kpi_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             req_op,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic signed [kpi_pkg::DATA_W-1:0] pos_x,
  input logic signed [kpi_pkg::DATA_W-1:0] pos_y,
  input logic signed [kpi_pkg::DATA_W-1:0] pos_z,
  input logic [kpi_pkg::KEY_IDX_W-1:0]    segment,
  input logic                             range_error
);
  import kpi_pkg::*;

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // Hold the response word until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(pos_z)
      && $stable(segment) && $stable(range_error))
    else $error("stalled response changed");

  // One query at a time: the request side closes right after a query
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_op == OP_QUERY |=> !req_ready)
    else $error("request taken while a query is in flight");

  // A key write never produces a response word
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_op == OP_WRITE && !rsp_valid |=> !rsp_valid)
    else $error("response raised by a key write");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid straight after reset");

endmodule

bind keyframe_position_interpolator kpi_checker u_kpi_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_op      (req.op),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .pos_x       (rsp.pos_x),
  .pos_y       (rsp.pos_y),
  .pos_z       (rsp.pos_z),
  .segment     (rsp.segment),
  .range_error (rsp.range_error)
);
